// ===== rtl/core/rlps_pkg.sv =====
// Shared types, codes and helpers for the serial RGB LED pulse-width encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rlps_pkg;

  localparam int BITS_PER_PIXEL = 24;          // 24..32, extra bits go out as zeros
  localparam int COLOR_W        = 24;
  localparam int PIX_W          = BITS_PER_PIXEL;
  localparam int BITCNT_W       = $clog2(BITS_PER_PIXEL);
  localparam int TIMER_W        = 16;
  localparam int BIT_TIME_W     = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  // command codes on s_tuser
  localparam logic [1:0] CMD_IDLE  = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_LATCH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

  localparam logic [BIT_TIME_W-1:0] ONE_HIGH_RST  = 12'd35;
  localparam logic [BIT_TIME_W-1:0] ONE_LOW_RST   = 12'd30;
  localparam logic [BIT_TIME_W-1:0] ZERO_HIGH_RST = 12'd17;
  localparam logic [BIT_TIME_W-1:0] ZERO_LOW_RST  = 12'd40;
  localparam logic [TIMER_W-1:0]    LATCH_RST     = 16'd350;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SEND,
    KIND_LATCH
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COLOR_W-1:0] pixel;   // green, red, blue from the top down
  } item_t;

  typedef struct packed {
    logic [BIT_TIME_W-1:0] one_high;
    logic [BIT_TIME_W-1:0] one_low;
    logic [BIT_TIME_W-1:0] zero_high;
    logic [BIT_TIME_W-1:0] zero_low;
    logic [TIMER_W-1:0]    latch;
  } cfg_t;

  typedef struct packed {
    logic accepted;
    logic ready_res;
    logic line_level;
  } result_t;

  // a programmed zero is raised to one
  function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
    at_least_one = (v == '0) ? TIMER_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgb_led_pulse_width_serializer.sv =====
// Top level of the serial RGB LED pulse-width encoder: configuration
// registers, command front end and waveform engine. Depends on rlps_pkg,
// rlps_front and rlps_engine.
// Between an input transfer and its result lie the queue entry and then the
// registered result stage of one engine step; output stalls can hold it.
// Throughput: one tick per cycle while the output channel accepts results, limited by the single-step waveform engine.
// Reset: queue and result stage empty, line idle, timing registers at defaults.
`default_nettype none

module rgb_led_pulse_width_serializer (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire  [23:0]                     s_tdata,    // red, green, blue from bit 0 up
  input  wire  [1:0]                      s_tuser,    // cmd
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [7:0]                      m_tdata,    // line_level, ready_res, accepted
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [rlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [rlps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlps_pkg::*;

  cfg_t   cfg;
  item_t  item;
  logic   item_valid;
  logic   item_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high  <= ONE_HIGH_RST;
      cfg.one_low   <= ONE_LOW_RST;
      cfg.zero_high <= ZERO_HIGH_RST;
      cfg.zero_low  <= ZERO_LOW_RST;
      cfg.latch     <= LATCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ONE_HIGH:  cfg.one_high  <= cfg_data[BIT_TIME_W-1:0];
        REG_ONE_LOW:   cfg.one_low   <= cfg_data[BIT_TIME_W-1:0];
        REG_ZERO_HIGH: cfg.zero_high <= cfg_data[BIT_TIME_W-1:0];
        REG_ZERO_LOW:  cfg.zero_low  <= cfg_data[BIT_TIME_W-1:0];
        REG_LATCH:     cfg.latch     <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  rlps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  rlps_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rlps_front.sv =====
// Front end: decodes the command of each input transfer and holds it in a
// two-entry queue for the waveform engine. Depends on rlps_pkg.
`default_nettype none

module rlps_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [rlps_pkg::COLOR_W-1:0] s_tdata,   // red, green, blue from bit 0 up
  input  wire  [1:0]                   s_tuser,   // cmd
  output logic                         item_valid,
  input  wire                          item_ready,
  output rlps_pkg::item_t              item
);
  import rlps_pkg::*;

  item_t       queue [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  item_t       decoded;
  logic        push;
  logic        pop;

  always_comb begin
    decoded.pixel = {s_tdata[15:8], s_tdata[7:0], s_tdata[23:16]};
    unique case (s_tuser)
      CMD_SEND:  decoded.kind = KIND_SEND;
      CMD_LATCH: decoded.kind = KIND_LATCH;
      default:   decoded.kind = KIND_NONE;
    endcase
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("front queue count out of range");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 2'd1)
    else $error("front queue count did not drop on a lone pop");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("front queue count did not rise on a lone push");

endmodule

`default_nettype wire

// ===== rtl/core/rlps_engine.sv =====
// Back end: pulse-width waveform engine, one queued tick per cycle while the output
// channel does not stall, with a registered result stage toward it. Depends on rlps_pkg.
`default_nettype none

module rlps_engine (
  input  wire              clk,
  input  wire              rst,
  input  rlps_pkg::cfg_t   cfg,
  input  wire              item_valid,
  output logic             item_ready,
  input  rlps_pkg::item_t  item,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [7:0]       m_tdata    // line_level, ready_res, accepted from bit 0 up
);
  import rlps_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_LATCH
  } phase_t;

  phase_t               phase, phase_next;
  logic [PIX_W-1:0]     shift_bits, shift_bits_next;
  logic [BITCNT_W-1:0]  bits_left, bits_left_next;
  logic [TIMER_W-1:0]   cycle_timer, cycle_timer_next;
  result_t              result, result_next;
  logic                 pop;

  function automatic logic [TIMER_W-1:0] high_time(input cfg_t c, input logic b);
    high_time = at_least_one(TIMER_W'(b ? c.one_high : c.zero_high));
  endfunction

  function automatic logic [TIMER_W-1:0] low_time(input cfg_t c, input logic b);
    low_time = at_least_one(TIMER_W'(b ? c.one_low : c.zero_low));
  endfunction

  assign item_ready = !m_tvalid || m_tready;
  assign pop        = item_valid && item_ready;
  assign m_tdata    = {5'b0, result};

  always_comb begin
    phase_next       = phase;
    shift_bits_next  = shift_bits;
    bits_left_next   = bits_left;
    cycle_timer_next = cycle_timer;
    result_next.line_level = 1'b0;
    result_next.ready_res  = (phase == PH_IDLE);
    result_next.accepted   = 1'b0;

    if (phase == PH_IDLE) begin
      unique case (item.kind)
        KIND_SEND: begin
          shift_bits_next  = PIX_W'(item.pixel) << (PIX_W - COLOR_W);
          bits_left_next   = BITCNT_W'(BITS_PER_PIXEL - 1);
          phase_next       = PH_HIGH;
          cycle_timer_next = high_time(cfg, item.pixel[COLOR_W-1]);
          result_next.accepted = 1'b1;
        end
        KIND_LATCH: begin
          phase_next       = PH_LATCH;
          cycle_timer_next = at_least_one(cfg.latch);
          result_next.accepted = 1'b1;
        end
        default: ;
      endcase
    end

    if (phase_next != PH_IDLE) begin
      result_next.line_level = (phase_next == PH_HIGH);
      // timer holds cycles left including this one, so 1 means last cycle
      if (cycle_timer_next == TIMER_W'(1)) begin
        unique case (phase_next)
          PH_HIGH: begin
            phase_next       = PH_LOW;
            cycle_timer_next = low_time(cfg, shift_bits_next[PIX_W-1]);
          end
          PH_LOW: begin
            if (bits_left_next == '0) begin
              phase_next = PH_IDLE;
            end else begin
              shift_bits_next  = shift_bits_next << 1;
              bits_left_next   = bits_left_next - BITCNT_W'(1);
              phase_next       = PH_HIGH;
              cycle_timer_next = high_time(cfg, shift_bits_next[PIX_W-1]);
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end else begin
        cycle_timer_next = cycle_timer_next - TIMER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      shift_bits  <= '0;
      bits_left   <= '0;
      cycle_timer <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        shift_bits  <= shift_bits_next;
        bits_left   <= bits_left_next;
        cycle_timer <= cycle_timer_next;
      end
      m_tvalid <= pop || (m_tvalid && !m_tready);
    end
    if (pop) begin
      result <= result_next;
    end
  end

  a_timer_live: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> cycle_timer != '0)
    else $error("active phase with an expired timer");
  // a latch programmed to zero or one may already be over, a pixel always spans a high and a low
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    pop && phase == PH_IDLE && item.kind == KIND_SEND |=> phase != PH_IDLE)
    else $error("accepted pixel did not leave idle");
  a_accept_when_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.accepted |-> result.ready_res)
    else $error("command reported taken while busy");
  a_latch_low: assert property (@(posedge clk) disable iff (rst)
    pop && phase == PH_LATCH |=> !result.line_level)
    else $error("line driven high during latch");

endmodule

`default_nettype wire
